// File: src/mif_pkg.sv
`default_nettype none

package mif_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_CELL_WIDTH = 2'd0;
    localparam logic [1:0] CFG_TIME_STEP  = 2'd1;
    localparam logic [1:0] CFG_INFIL_ON   = 2'd2;

    // flow direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // saturation limits
    localparam logic [47:0] FLOW_MAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] PROD_CAP   = 48'h8000_0000_0000;
    localparam logic [31:0] SF_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SF_NEG_MAX = 32'h8000_0000;

    // side data carried through the slope divider
    typedef struct packed {
        logic        neg;
        logic [31:0] h;
        logic [15:0] n;
        logic [32:0] need;
    } div1_side_t;

    // side data carried through the square root
    typedef struct packed {
        logic [31:0] sfraw;
        logic [1:0]  dir;
        logic        excess;
        logic [15:0] n;
        logic [31:0] x;
    } sqrt_side_t;

    // side data carried through the cube root
    typedef struct packed {
        logic [31:0] sfraw;
        logic [1:0]  dir;
        logic        excess;
        logic [15:0] n;
        logic [31:0] x;
        logic [39:0] a1;
        logic        big;
    } cbrt_side_t;

    // side data carried through the roughness divider
    typedef struct packed {
        logic [31:0] sfraw;
        logic [1:0]  dir;
        logic        excess;
        logic        pz;
    } div2_side_t;

endpackage

`default_nettype wire

// File: src/mif_div.sv
`default_nettype none

module mif_div
    import mif_pkg::*;
#(
    parameter int NW = 49,
    parameter int DW = 32,
    parameter int SW = 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [NW-1:0]      quot,
    output logic [SW-1:0]      side_out
);

    // one quotient bit per stage, restoring
    logic [NW-1:0] work_reg [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] dvs_reg  [NW];
    logic [SW-1:0] side_reg [NW];
    logic [NW-1:0] vld_reg;

    logic [NW-1:0] work_in  [NW];
    logic [DW-1:0] rem_in   [NW];
    logic [DW-1:0] dvs_in   [NW];
    logic [SW-1:0] side_in_s[NW];
    logic [DW:0]   shifted  [NW];
    logic [DW:0]   diff     [NW];
    logic          ge       [NW];
    logic [NW-1:0] work_next[NW];
    logic [DW-1:0] rem_next [NW];

    // stage inputs
    always_comb
    begin
        work_in[0]   = dividend;
        rem_in[0]    = '0;
        dvs_in[0]    = divisor;
        side_in_s[0] = side_in;
        for (int k = 1; k < NW; k++)
        begin
            work_in[k]   = work_reg[k-1];
            rem_in[k]    = rem_reg[k-1];
            dvs_in[k]    = dvs_reg[k-1];
            side_in_s[k] = side_reg[k-1];
        end
    end

    // trial subtract per stage
    always_comb
    begin
        for (int k = 0; k < NW; k++)
        begin
            shifted[k]   = {rem_in[k], work_in[k][NW-1]};
            diff[k]      = shifted[k] - {1'b0, dvs_in[k]};
            ge[k]        = shifted[k] >= {1'b0, dvs_in[k]};
            rem_next[k]  = ge[k] ? diff[k][DW-1:0] : shifted[k][DW-1:0];
            work_next[k] = {work_in[k][NW-2:0], ge[k]};
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NW-2:0], in_valid};
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NW; k++)
            begin
                work_reg[k] <= work_next[k];
                rem_reg[k]  <= rem_next[k];
                dvs_reg[k]  <= dvs_in[k];
                side_reg[k] <= side_in_s[k];
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quot      = work_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

`default_nettype wire

// File: src/mif_sqrt.sv
`default_nettype none

module mif_sqrt
    import mif_pkg::*;
#(
    parameter int NW = 48,
    parameter int SW = 1
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [NW-1:0]   radicand,
    input  wire logic [SW-1:0]   side_in,
    output logic                 out_valid,
    output logic [NW/2-1:0]      root,
    output logic [SW-1:0]        side_out
);

    localparam int RTW = NW / 2;
    localparam int RW  = RTW + 1;

    // one root bit per stage
    logic [NW-1:0]  work_reg [RTW];
    logic [RW-1:0]  rem_reg  [RTW];
    logic [RTW-1:0] root_reg [RTW];
    logic [SW-1:0]  side_reg [RTW];
    logic [RTW-1:0] vld_reg;

    logic [NW-1:0]  work_in  [RTW];
    logic [RW-1:0]  rem_in   [RTW];
    logic [RTW-1:0] root_in  [RTW];
    logic [SW-1:0]  side_in_s[RTW];
    logic [RW+1:0]  shifted  [RTW];
    logic [RW+1:0]  trial    [RTW];
    logic [RW+1:0]  diff     [RTW];
    logic           ge       [RTW];

    // stage inputs
    always_comb
    begin
        work_in[0]   = radicand;
        rem_in[0]    = '0;
        root_in[0]   = '0;
        side_in_s[0] = side_in;
        for (int k = 1; k < RTW; k++)
        begin
            work_in[k]   = work_reg[k-1];
            rem_in[k]    = rem_reg[k-1];
            root_in[k]   = root_reg[k-1];
            side_in_s[k] = side_reg[k-1];
        end
    end

    // trial subtract of 4r+1
    always_comb
    begin
        for (int k = 0; k < RTW; k++)
        begin
            shifted[k] = {rem_in[k], work_in[k][NW-1:NW-2]};
            trial[k]   = {1'b0, root_in[k], 2'b01};
            diff[k]    = shifted[k] - trial[k];
            ge[k]      = shifted[k] >= trial[k];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[RTW-2:0], in_valid};
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RTW; k++)
            begin
                work_reg[k] <= {work_in[k][NW-3:0], 2'b00};
                rem_reg[k]  <= ge[k] ? diff[k][RW-1:0] : shifted[k][RW-1:0];
                root_reg[k] <= {root_in[k][RTW-2:0], ge[k]};
                side_reg[k] <= side_in_s[k];
            end
        end
    end

    assign out_valid = vld_reg[RTW-1];
    assign root      = root_reg[RTW-1];
    assign side_out  = side_reg[RTW-1];

endmodule

`default_nettype wire

// File: src/mif_cbrt.sv
`default_nettype none

module mif_cbrt
    import mif_pkg::*;
#(
    parameter int NW = 64,
    parameter int SW = 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [NW-1:0]        value,
    input  wire logic [SW-1:0]        side_in,
    output logic                      out_valid,
    output logic [(NW+2)/3-1:0]       root,
    output logic [SW-1:0]             side_out
);

    localparam int YW = (NW + 2) / 3;
    localparam int PW = 3 * YW;
    localparam int RW = 2 * YW + 4;
    localparam int BW = 2 * YW + 3;

    // one root bit per stage, three value bits consumed each
    logic [PW-1:0] work_reg [YW];
    logic [RW-1:0] rem_reg  [YW];
    logic [YW-1:0] y_reg    [YW];
    logic [SW-1:0] side_reg [YW];
    logic [YW-1:0] vld_reg;

    logic [PW-1:0]   work_in  [YW];
    logic [RW-1:0]   rem_in   [YW];
    logic [YW-1:0]   y_in     [YW];
    logic [SW-1:0]   side_in_s[YW];
    logic [YW-1:0]   ys       [YW];
    logic [YW:0]     ys1      [YW];
    logic [2*YW:0]   yprod    [YW];
    logic [BW-1:0]   bterm    [YW];
    logic [RW+2:0]   shifted  [YW];
    logic [RW+2:0]   diff     [YW];
    logic            ge       [YW];

    // stage inputs
    always_comb
    begin
        work_in[0]   = {{(PW-NW){1'b0}}, value};
        rem_in[0]    = '0;
        y_in[0]      = '0;
        side_in_s[0] = side_in;
        for (int k = 1; k < YW; k++)
        begin
            work_in[k]   = work_reg[k-1];
            rem_in[k]    = rem_reg[k-1];
            y_in[k]      = y_reg[k-1];
            side_in_s[k] = side_reg[k-1];
        end
    end

    // trial subtract of 3y(y+1)+1
    always_comb
    begin
        for (int k = 0; k < YW; k++)
        begin
            ys[k]      = {y_in[k][YW-2:0], 1'b0};
            ys1[k]     = {1'b0, ys[k]} + {{YW{1'b0}}, 1'b1};
            yprod[k]   = (2*YW+1)'(ys[k]) * (2*YW+1)'(ys1[k]);
            bterm[k]   = {1'b0, yprod[k], 1'b0} + {2'b00, yprod[k]} + BW'(1);
            shifted[k] = {rem_in[k], work_in[k][PW-1:PW-3]};
            diff[k]    = shifted[k] - (RW+3)'(bterm[k]);
            ge[k]      = shifted[k] >= (RW+3)'(bterm[k]);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[YW-2:0], in_valid};
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < YW; k++)
            begin
                work_reg[k] <= {work_in[k][PW-4:0], 3'b000};
                rem_reg[k]  <= ge[k] ? diff[k][RW-1:0] : shifted[k][RW-1:0];
                y_reg[k]    <= {y_in[k][YW-2:0], ge[k]};
                side_reg[k] <= side_in_s[k];
            end
        end
    end

    assign out_valid = vld_reg[YW-1];
    assign root      = y_reg[YW-1];
    assign side_out  = side_reg[YW-1];

endmodule

`default_nettype wire

// File: src/manning_interface_flow.sv
`default_nettype none

// channel  dir  signals                       contents
// s_       in   s_tvalid s_tready s_tdata     one cell pair (face)
// m_       out  m_tvalid m_tready m_tdata     flow, direction, slope
// cfg_     in   cfg_we cfg_index cfg_data     cell width, time step, infiltration
//
// one face enters per cycle when not held; the path is the 49 stage slope
// divider, the 24 stage square root, the 22 stage cube root and the 64 stage
// roughness divider plus the multiply and output stages
// reset clears the valid bits and loads the register defaults
// the whole pipeline holds while the output word waits on m_tready

module manning_interface_flow
    import mif_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // elev_here, elev_next, depth_here, depth_next, rough_here, rough_next,
    // store_here, store_next, infil_here, infil_next
    input  wire logic [287:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // face_flow, flow_dir, fric_slope, zero fill
    output logic [87:0]       m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    typedef struct packed {
        logic [31:0] sfraw;
        logic [1:0]  dir;
        logic        excess;
        logic [15:0] n;
    } tail_t;

    // configuration registers
    logic [31:0] cell_width_reg;
    logic [31:0] time_step_reg;
    logic        infil_on_reg;
    logic [31:0] w1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg <= 32'h0001_0000;
            time_step_reg  <= 32'h0001_0000;
            infil_on_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CELL_WIDTH: cell_width_reg <= cfg_data;
                CFG_TIME_STEP:  time_step_reg  <= cfg_data;
                CFG_INFIL_ON:   infil_on_reg   <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign w1 = (cell_width_reg == '0) ? 32'd1 : cell_width_reg;

    // pipeline advances unless the output word is held
    logic adv;
    logic o_vld_reg;

    assign adv      = !o_vld_reg || m_tready;
    assign s_tready = adv;

    // input unpack
    logic [31:0] elev_here, elev_next, depth_here, depth_next;
    logic [15:0] rough_here, rough_next;
    logic [31:0] store_here, store_next, infil_here, infil_next;

    assign elev_here  = s_tdata[31:0];
    assign elev_next  = s_tdata[63:32];
    assign depth_here = s_tdata[95:64];
    assign depth_next = s_tdata[127:96];
    assign rough_here = s_tdata[143:128];
    assign rough_next = s_tdata[159:144];
    assign store_here = s_tdata[191:160];
    assign store_next = s_tdata[223:192];
    assign infil_here = s_tdata[255:224];
    assign infil_next = s_tdata[287:256];

    // slope numerator and upstream selection by its sign
    logic [33:0] num;
    logic [33:0] um_full;
    logic        neg_next;
    logic [63:0] inf_prod;
    logic [31:0] inf_next;

    assign num = {{2{elev_here[31]}}, elev_here} - {{2{elev_next[31]}}, elev_next}
               + {2'b00, depth_here} - {2'b00, depth_next};
    assign neg_next = num[33];
    assign um_full  = neg_next ? (34'd0 - num) : num;
    assign inf_prod = 64'(neg_next ? infil_next : infil_here) * 64'(time_step_reg);
    assign inf_next = infil_on_reg ? inf_prod[63:32] : 32'd0;

    logic        a_vld_reg;
    logic [32:0] a_um_reg;
    logic        a_neg_reg;
    logic [31:0] a_h_reg;
    logic [15:0] a_n_reg;
    logic [31:0] a_st_reg;
    logic [31:0] a_inf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_um_reg  <= um_full[32:0];
            a_neg_reg <= neg_next;
            a_h_reg   <= neg_next ? depth_next : depth_here;
            a_n_reg   <= neg_next ? rough_next : rough_here;
            a_st_reg  <= neg_next ? store_next : store_here;
            a_inf_reg <= inf_next;
        end
    end

    // slope divider
    div1_side_t d1_side_in, d1_side;
    logic        d1_vld;
    logic [48:0] d1_q;

    always_comb
    begin
        d1_side_in.neg  = a_neg_reg;
        d1_side_in.h    = a_h_reg;
        d1_side_in.n    = a_n_reg;
        d1_side_in.need = {1'b0, a_st_reg} + {1'b0, a_inf_reg};
    end

    mif_div #(.NW(49), .DW(32), .SW($bits(div1_side_t))) u_div_slope (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (a_vld_reg),
        .dividend  ({a_um_reg, 16'h0000}),
        .divisor   (w1),
        .side_in   (d1_side_in),
        .out_valid (d1_vld),
        .quot      (d1_q),
        .side_out  (d1_side)
    );

    // slope saturation, direction and excess depth
    logic [31:0] smag_next;
    sqrt_side_t  b_side_next;

    always_comb
    begin
        if (d1_side.neg)
        begin
            smag_next = (d1_q > 49'(SF_NEG_MAX)) ? SF_NEG_MAX : d1_q[31:0];
        end
        else
        begin
            smag_next = (d1_q > 49'(SF_POS_MAX)) ? SF_POS_MAX : d1_q[31:0];
        end
        b_side_next.sfraw  = d1_side.neg ? (32'd0 - smag_next) : smag_next;
        b_side_next.dir    = (smag_next == '0) ? DIR_NONE : (d1_side.neg ? DIR_REV : DIR_FWD);
        b_side_next.excess = {1'b0, d1_side.h} > d1_side.need;
        b_side_next.n      = d1_side.n;
        b_side_next.x      = d1_side.h - d1_side.need[31:0];
    end

    logic        b_vld_reg;
    logic [31:0] b_smag_reg;
    sqrt_side_t  b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_smag_reg <= smag_next;
            b_side_reg <= b_side_next;
        end
    end

    // square root of the slope
    sqrt_side_t  sq_side;
    logic        sq_vld;
    logic [23:0] sq_root;

    mif_sqrt #(.NW(48), .SW($bits(sqrt_side_t))) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (b_vld_reg),
        .radicand  ({b_smag_reg, 16'h0000}),
        .side_in   (b_side_reg),
        .out_valid (sq_vld),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // x squared and width times root
    logic        c_vld_reg;
    logic [63:0] c_x2_reg;
    logic [55:0] c_wsq_reg;
    sqrt_side_t  c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_x2_reg   <= 64'(sq_side.x) * 64'(sq_side.x);
            c_wsq_reg  <= 56'(w1) * 56'(sq_root);
            c_side_reg <= sq_side;
        end
    end

    // cube root operand scaling
    logic        big_next;
    logic        d_vld_reg;
    logic [63:0] d_cin_reg;
    cbrt_side_t  d_side_reg;

    assign big_next = c_x2_reg[63:48] != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_cin_reg         <= big_next ? {2'b00, c_x2_reg[63:2]}
                                          : {c_x2_reg[47:0], 16'h0000};
            d_side_reg.sfraw  <= c_side_reg.sfraw;
            d_side_reg.dir    <= c_side_reg.dir;
            d_side_reg.excess <= c_side_reg.excess;
            d_side_reg.n      <= c_side_reg.n;
            d_side_reg.x      <= c_side_reg.x;
            d_side_reg.a1     <= c_wsq_reg[55:16];
            d_side_reg.big    <= big_next;
        end
    end

    // cube root of x squared
    cbrt_side_t  cb_side;
    logic        cb_vld;
    logic [21:0] cb_y;

    mif_cbrt #(.NW(64), .SW($bits(cbrt_side_t))) u_cbrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_vld_reg),
        .value     (d_cin_reg),
        .side_in   (d_side_reg),
        .out_valid (cb_vld),
        .root      (cb_y),
        .side_out  (cb_side)
    );

    // partial products of a1 times x
    logic        e_vld_reg;
    logic [55:0] e_ppl_reg;
    logic [47:0] e_pph_reg;
    logic [27:0] e_p_reg;
    tail_t       e_tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_vld_reg <= cb_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_ppl_reg         <= 56'(cb_side.a1[23:0]) * 56'(cb_side.x);
            e_pph_reg         <= 48'(cb_side.a1[39:24]) * 48'(cb_side.x);
            e_p_reg           <= cb_side.big ? {cb_y, 6'b000000} : {6'b000000, cb_y};
            e_tail_reg.sfraw  <= cb_side.sfraw;
            e_tail_reg.dir    <= cb_side.dir;
            e_tail_reg.excess <= cb_side.excess;
            e_tail_reg.n      <= cb_side.n;
        end
    end

    // combine, scale and cap
    logic [72:0] full1;
    logic [56:0] s1;
    logic        f_vld_reg;
    logic [47:0] f_a2_reg;
    logic [27:0] f_p_reg;
    tail_t       f_tail_reg;

    assign full1 = {1'b0, e_pph_reg, 24'h000000} + 73'(e_ppl_reg);
    assign s1    = full1[72:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_a2_reg   <= (s1 > 57'(PROD_CAP)) ? PROD_CAP : s1[47:0];
            f_p_reg    <= e_p_reg;
            f_tail_reg <= e_tail_reg;
        end
    end

    // partial products of a2 times x^(2/3)
    logic        g_vld_reg;
    logic [51:0] g_qql_reg;
    logic [51:0] g_qqh_reg;
    tail_t       g_tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_qql_reg  <= 52'(f_a2_reg[23:0]) * 52'(f_p_reg);
            g_qqh_reg  <= 52'(f_a2_reg[47:24]) * 52'(f_p_reg);
            g_tail_reg <= f_tail_reg;
        end
    end

    // combine, scale and cap
    logic [76:0] full2;
    logic [60:0] s2;
    logic        h_vld_reg;
    logic [47:0] h_prod_reg;
    tail_t       h_tail_reg;

    assign full2 = {1'b0, g_qqh_reg, 24'h000000} + 77'(g_qql_reg);
    assign s2    = full2[76:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            h_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_prod_reg <= (s2 > 61'(PROD_CAP)) ? PROD_CAP : s2[47:0];
            h_tail_reg <= g_tail_reg;
        end
    end

    // division by roughness
    div2_side_t  d2_side_in, q2_side;
    logic        q2_vld;
    logic [63:0] q2;

    always_comb
    begin
        d2_side_in.sfraw  = h_tail_reg.sfraw;
        d2_side_in.dir    = h_tail_reg.dir;
        d2_side_in.excess = h_tail_reg.excess;
        d2_side_in.pz     = h_prod_reg == '0;
    end

    mif_div #(.NW(64), .DW(16), .SW($bits(div2_side_t))) u_div_rough (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (h_vld_reg),
        .dividend  ({h_prod_reg, 16'h0000}),
        .divisor   (h_tail_reg.n),
        .side_in   (d2_side_in),
        .out_valid (q2_vld),
        .quot      (q2),
        .side_out  (q2_side)
    );

    // output word
    logic [47:0] mag_next;
    logic [47:0] flow_next;
    logic [47:0] o_flow_reg;
    logic [1:0]  o_dir_reg;
    logic [31:0] o_sf_reg;

    always_comb
    begin
        mag_next  = (q2 > 64'(FLOW_MAX)) ? FLOW_MAX : q2[47:0];
        flow_next = (q2_side.excess && (q2_side.dir != DIR_NONE) && !q2_side.pz)
                  ? mag_next : 48'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            o_vld_reg <= q2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_flow_reg <= (q2_side.dir == DIR_REV) ? (48'd0 - flow_next) : flow_next;
            o_dir_reg  <= q2_side.dir;
            o_sf_reg   <= q2_side.sfraw;
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = {6'b000000, o_sf_reg, o_dir_reg, o_flow_reg};

endmodule

`default_nettype wire

// File: sim/tb_manning_interface_flow.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_manning_interface_flow;
    import mif_pkg::*;

    localparam int PIPE_LAT = 169;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // elev_here, elev_next, depth_here, depth_next, rough_here, rough_next,
    // store_here, store_next, infil_here, infil_next
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // face_flow, flow_dir, fric_slope, zero fill
    logic [87:0]  m_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    typedef struct packed {
        logic [31:0] infil_next;
        logic [31:0] infil_here;
        logic [31:0] store_next;
        logic [31:0] store_here;
        logic [15:0] rough_next;
        logic [15:0] rough_here;
        logic [31:0] depth_next;
        logic [31:0] depth_here;
        logic [31:0] elev_next;
        logic [31:0] elev_here;
    } face_t;

    typedef struct packed {
        logic [31:0] slope;
        logic [1:0]  dir;
        logic [47:0] flow;
    } flow_t;

    // local copy of the registers
    logic [31:0] width_reg;
    logic [31:0] step_reg;
    logic        infil_reg;

    flow_t flow_queue[$];
    int    mismatch_count;
    int    sender_idle_pct;
    int    receiver_stall_pct;
    int    hold_cycles;

    manning_interface_flow DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // integer square root, bit by bit
    function automatic logic [63:0] root2(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // integer cube root, three bits per step
    function automatic logic [63:0] root3(input logic [63:0] v);
        logic [63:0] y;
        logic [63:0] b;
        y = 0;
        for (int s = 63; s >= 0; s -= 3)
        begin
            y = y << 1;
            b = 3 * y * (y + 1) + 1;
            if ((v >> s) >= b)
            begin
                v = v - (b << s);
                y = y + 1;
            end
        end
        return y;
    endfunction

    // scaled product capped at 2^47
    function automatic logic [63:0] cap_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> 16;
        if (p > {80'd0, PROD_CAP})
            return {16'd0, PROD_CAP};
        return p[63:0];
    endfunction

    function automatic flow_t face_flow_of(input face_t f);
        flow_t       r;
        logic signed [63:0] num;
        logic [63:0] w, um, mag, smag, h, n, st, inf, need, x, x2, p, sq, prod, fl;
        logic        neg;
        logic        up;
        num = 64'(signed'(f.elev_here)) - 64'(signed'(f.elev_next))
            + 64'(f.depth_here) - 64'(f.depth_next);
        w = (width_reg == 0) ? 64'd1 : 64'(width_reg);
        neg = num < 0;
        um = neg ? 64'(-num) : 64'(num);
        mag = (um << 16) / w;
        fl = 0;
        if (neg)
        begin
            smag = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
            r.slope = 32'(0 - smag);
        end
        else
        begin
            smag = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
            r.slope = smag[31:0];
        end
        r.dir = (smag == 0) ? DIR_NONE : (neg ? DIR_REV : DIR_FWD);
        if (r.dir != DIR_NONE)
        begin
            up = (r.dir == DIR_REV);
            h = up ? f.depth_next : f.depth_here;
            n = up ? f.rough_next : f.rough_here;
            st = up ? f.store_next : f.store_here;
            inf = infil_reg ? ((64'(up ? f.infil_next : f.infil_here) * step_reg) >> 32) : 0;
            need = st + inf;
            if (h > need)
            begin
                x = h - need;
                x2 = x * x;
                p = (x2 < (64'd1 << 48)) ? root3(x2 << 16) : (root3(x2 >> 2) << 6);
                sq = root2(smag << 16);
                prod = cap_mul(cap_mul(cap_mul(w, sq), x), p);
                if (n == 0)
                    fl = (prod != 0) ? 64'(FLOW_MAX) : 0;
                else
                    fl = (prod << 16) / n;
                if (fl > 64'(FLOW_MAX))
                    fl = 64'(FLOW_MAX);
            end
        end
        r.flow = (r.dir == DIR_REV) ? 48'(0 - fl) : fl[47:0];
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CELL_WIDTH)
            width_reg = val;
        else if (idx == CFG_TIME_STEP)
            step_reg = val;
        else if (idx == CFG_INFIL_ON)
            infil_reg = val[0];
    endtask

    // drain, then let the pipeline settle before a register write
    task automatic wait_idle();
        while (flow_queue.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 10) @(negedge clk);
    endtask

    // offer one word, called at a falling edge, returns at a falling edge
    task automatic send_face(input face_t f);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        flow_queue.push_back(face_flow_of(f));
        @(negedge clk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    function automatic face_t random_face();
        face_t f;
        f = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
        // mostly modest depths and elevations so flow is often nonzero
        if ($urandom_range(3) != 0)
        begin
            f.elev_here = $urandom_range(2000000) - 1000000;
            f.elev_next = $urandom_range(2000000) - 1000000;
            f.depth_here = $urandom_range(4000000);
            f.depth_next = $urandom_range(4000000);
            f.store_here = $urandom_range(200000);
            f.store_next = $urandom_range(200000);
            f.infil_here = $urandom >> $urandom_range(31);
            f.infil_next = $urandom >> $urandom_range(31);
        end
        if ($urandom_range(9) == 0)
            f.rough_here = 16'd1 << $urandom_range(15);
        if ($urandom_range(9) == 0)
            f.rough_next = 16'hFFFF;
        if (f.rough_here == 0)
            f.rough_here = 16'd1;
        if (f.rough_next == 0)
            f.rough_next = 16'd1;
        return f;
    endfunction

    task automatic test_directed();
        face_t f;
        // flat ground and equal depth: zero slope
        f = '0;
        f.rough_here = 16'd1;
        f.rough_next = 16'd1;
        send_face(f);
        // forward flow, both directions, extremes
        f.elev_here = 32'h7FFF_FFFF;
        f.elev_next = 32'h8000_0000;
        f.depth_here = 32'hFFFF_FFFF;
        send_face(f);
        f.elev_here = 32'h8000_0000;
        f.elev_next = 32'h7FFF_FFFF;
        f.depth_here = 0;
        f.depth_next = 32'hFFFF_FFFF;
        f.rough_next = 16'hFFFF;
        send_face(f);
        // depth below storage
        f = '0;
        f.elev_here = 32'h0001_0000;
        f.depth_here = 32'h0002_0000;
        f.store_here = 32'h0003_0000;
        f.rough_here = 16'h0800;
        f.rough_next = 16'h0800;
        send_face(f);
        // depth above storage, small numbers
        f.store_here = 32'h0000_8000;
        send_face(f);
        f.store_here = 32'hFFFF_FFFF;
        f.store_next = 32'hFFFF_FFFF;
        f.infil_here = 32'hFFFF_FFFF;
        f.infil_next = 32'hFFFF_FFFF;
        send_face(f);
        // forward slope from a small elevation and depth drop
        f = '0;
        f.elev_here = 32'd1;
        f.depth_here = 32'h0001_0000;
        f.rough_here = 16'h1000;
        f.rough_next = 16'h1000;
        send_face(f);
        f.depth_next = 32'h0004_0000;
        f.depth_here = 32'h0000_0000;
        f.elev_next = 32'hFFFF_0000;
        send_face(f);
        for (int i = 0; i < 12; i++)
            send_face(random_face());
        stop_sending();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_face(random_face());
        stop_sending();
    endtask

    task automatic test_config(input logic [31:0] w, input logic [31:0] ts,
                               input logic on, input int count);
        wait_idle();
        write_reg(CFG_CELL_WIDTH, w);
        write_reg(CFG_TIME_STEP, ts);
        write_reg(CFG_INFIL_ON, {31'd0, on});
        test_directed();
        test_random(count);
    endtask

    // receiver holds off for a long stretch while the sender keeps going
    task automatic test_backpressure();
        wait_idle();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_cycles = 400;
        test_random(180);
        hold_cycles = 0;
    endtask

    // receiver side: ready with random stalls or a counted hold
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // result checker
    initial
    begin
        flow_t got;
        flow_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = m_tdata[81:0];
                if (flow_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word %h", m_tdata);
                end
                else
                begin
                    want = flow_queue.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("word: flow %h/%h dir %0d/%0d slope %h/%h (exp/act)",
                                     want.flow, got.flow, want.dir, got.dir,
                                     want.slope, got.slope);
                    end
                end
            end
        end
    end

    initial
    begin
        #60000000;
        $display("manning_interface_flow: mismatch");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        hold_cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        width_reg = 32'h0001_0000;
        step_reg = 32'h0001_0000;
        infil_reg = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_CELL_WIDTH;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset defaults, no idling
        test_directed();
        test_random(200);
        // sender idle
        sender_idle_pct = 81;
        test_config(32'h0001_0000, 32'hFFFF_FFFF, 1'b1, 150);
        // receiver stalling
        sender_idle_pct = 0;
        receiver_stall_pct = 81;
        test_config(32'hFFFF_FFFF, 32'd0, 1'b1, 150);
        // both
        sender_idle_pct = 28;
        receiver_stall_pct = 28;
        test_config(32'd0, 32'h0010_0000, 1'b1, 150);
        test_config(32'h0000_4000, 32'h0000_0001, 1'b0, 150);
        test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        test_config(32'h0032_0000, 32'h0E10_0000, 1'b1, 150);

        while (flow_queue.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 20) @(negedge clk);
        if (mismatch_count == 0 && flow_queue.size() == 0)
            $display("manning_interface_flow: match");
        else
            $display("manning_interface_flow: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
